/* sv/rti_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rti_pkg
// Shared types and constants of the ray/triangle intersection unit.
// ----------------------------------------------------------------------------
package rti_pkg;

   // request kinds carried in tuser
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_RAY  = 1'b1;

   // register index, taken from paddr[2]
   localparam logic REG_DET_THRESHOLD = 1'b0;
   localparam logic REG_MIN_DISTANCE  = 1'b1;

   localparam int CFG_BITS  = 16;
   localparam int DIST_BITS = 31;
   localparam int IN_BITS   = 32;

   localparam logic [CFG_BITS-1:0] DET_THRESHOLD_RST = 16'd1;
   localparam logic [CFG_BITS-1:0] MIN_DISTANCE_RST  = 16'd7;

   localparam logic [1:0] VERTEX_0 = 2'd0;
   localparam logic [1:0] VERTEX_1 = 2'd1;
   localparam logic [1:0] VERTEX_2 = 2'd2;
   localparam logic [1:0] VERTEX_NONE = 2'd3;

   typedef struct packed {
      logic [CFG_BITS-1:0] det_threshold;
      logic [CFG_BITS-1:0] min_distance;
   } cfg_type;

endpackage
`default_nettype wire

/* sv/ray_triangle_intersect_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ray_triangle_intersect_unit
// Fixed-point ray/triangle intersection test with a three-vertex store.
// ----------------------------------------------------------------------------
// Request channel (req_): tuser selects a vertex load or a ray test. A load
// writes the vertex store and returns nothing; a ray returns one transaction
// on the response channel (rsp_) with the hit flag in tuser and the distance
// in tdata. Rays see every load accepted before them.
// One request is taken per cycle while the queue is not full. A ray result
// comes from the arithmetic pipeline (cross products, split dot products,
// tests and a 31-stage restoring divider, one quotient bit per stage).
// A four-entry queue lies between the front end and the pipeline. When a
// response is valid and rsp_tready is low, the whole pipeline holds, the
// queue fills and req_tready drops once it is full; loads are held off too.
// Reset clears the vertex store to zero, empties the queue and pipeline and
// loads det_threshold = 1 and min_distance = 7. Registers sit on the csr_
// port at byte addresses 0 and 4 and should be written while no ray is in
// flight.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_unit #(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic         req_tuser,    // func
   // vertex_sel[1:0], pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, zero pad
   input  wire logic [199:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic              rsp_tuser,    // hit
   output logic [31:0]       rsp_tdata,    // distance[30:0], zero pad
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   localparam int VW = 12 * (COORD_BITS + 1);
   localparam int CB = rti_pkg::CFG_BITS;

   rti_pkg::cfg_type cfg_ff, cfg_in;
   logic             csr_write;
   logic             q_full, q_push, q_pop, q_not_empty;
   logic [VW-1:0]    q_push_data, q_head_data;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            rti_pkg::REG_DET_THRESHOLD: cfg_in.det_threshold = csr_pwdata[CB-1:0];
            rti_pkg::REG_MIN_DISTANCE:  cfg_in.min_distance  = csr_pwdata[CB-1:0];
         endcase
      end
      unique case (csr_paddr[2])
         rti_pkg::REG_DET_THRESHOLD: csr_prdata = 32'(cfg_ff.det_threshold);
         rti_pkg::REG_MIN_DISTANCE:  csr_prdata = 32'(cfg_ff.min_distance);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.det_threshold <= rti_pkg::DET_THRESHOLD_RST;
         cfg_ff.min_distance  <= rti_pkg::MIN_DISTANCE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rti_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_push_data)
   );

   rti_queue #(.WIDTH(VW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_data (q_head_data)
   );

   rti_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_not_empty (q_not_empty),
      .q_data      (q_head_data),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata)
   );

endmodule
`default_nettype wire

/* sv/rti_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rti_queue
// Four-entry queue between the ray front end and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module rti_queue #(
   parameter int WIDTH = 396
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  not_empty,
   output logic [WIDTH-1:0]      head_data
);
   localparam int AW    = 2;
   localparam int DEPTH = 1 << AW;

   logic [WIDTH-1:0] entry_ff [0:DEPTH-1];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;

   assign full      = (count_ff == (AW+1)'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + AW'(push);
      rd_ptr_in = rd_ptr_ff + AW'(pop);
      count_in  = count_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

/* sv/rti_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rti_front
// Accepts request transactions: loads update the vertex store, rays have
// their edge and origin vectors formed and are queued for the pipeline.
// ----------------------------------------------------------------------------
module rti_front #(
   parameter int COORD_BITS = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic                          req_tuser,
   input  wire logic [199:0]                  req_tdata,
   input  wire logic                          q_full,
   output logic                               q_push,
   output logic [12*(COORD_BITS+1)-1:0]       q_data
);
   localparam int C  = COORD_BITS;
   localparam int E  = C + 1;
   localparam int IW = rti_pkg::IN_BITS;
   localparam int XW = (C > IW) ? C : IW;

   logic signed [C-1:0] vtx_ff [0:2][0:2];
   logic signed [C-1:0] pos    [0:2];
   logic signed [C-1:0] dir    [0:2];
   logic signed [XW-1:0] pos_ext [0:2];
   logic signed [XW-1:0] dir_ext [0:2];
   logic signed [E-1:0] e1 [0:2];
   logic signed [E-1:0] e2 [0:2];
   logic signed [E-1:0] sv [0:2];
   logic signed [E-1:0] dv [0:2];
   logic [1:0]          vertex_sel;
   logic                accept;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign vertex_sel = req_tdata[1:0];
   assign q_push     = accept && (req_tuser == rti_pkg::FUNC_RAY);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pos_ext[i] = XW'($signed(req_tdata[2 + IW*i +: IW]));
         dir_ext[i] = XW'($signed(req_tdata[2 + IW*(3+i) +: IW]));
         pos[i]     = pos_ext[i][C-1:0];
         dir[i]     = dir_ext[i][C-1:0];
         e1[i]      = E'(vtx_ff[1][i]) - E'(vtx_ff[0][i]);
         e2[i]      = E'(vtx_ff[2][i]) - E'(vtx_ff[0][i]);
         sv[i]      = E'(pos[i]) - E'(vtx_ff[0][i]);
         dv[i]      = E'(dir[i]);
      end
      q_data = {dv[2], dv[1], dv[0], sv[2], sv[1], sv[0],
                e2[2], e2[1], e2[0], e1[2], e1[1], e1[0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int v = 0; v < 3; v++) begin
            for (int i = 0; i < 3; i++) begin
               vtx_ff[v][i] <= '0;
            end
         end
      end else if (accept && (req_tuser == rti_pkg::FUNC_LOAD)) begin
         unique case (vertex_sel)
            rti_pkg::VERTEX_0: begin
               for (int i = 0; i < 3; i++) vtx_ff[0][i] <= pos[i];
            end
            rti_pkg::VERTEX_1: begin
               for (int i = 0; i < 3; i++) vtx_ff[1][i] <= pos[i];
            end
            rti_pkg::VERTEX_2: begin
               for (int i = 0; i < 3; i++) vtx_ff[2][i] <= pos[i];
            end
            rti_pkg::VERTEX_NONE: begin
            end
         endcase
      end
   end

endmodule
`default_nettype wire

/* sv/rti_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rti_back
// Intersection pipeline: cross products, split dot products, sign fix-up,
// bound tests and a one-bit-per-stage restoring divider for the distance.
// ----------------------------------------------------------------------------
module rti_back #(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire rti_pkg::cfg_type            cfg,
   input  wire logic                        q_not_empty,
   input  wire logic [12*(COORD_BITS+1)-1:0] q_data,
   output logic                             q_pop,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic                             rsp_tuser,
   output logic [31:0]                      rsp_tdata
);
   localparam int C   = COORD_BITS;
   localparam int F   = FRAC_BITS;
   localparam int E   = C + 1;
   localparam int VW  = 12 * E;
   localparam int PC  = 2 * E;
   localparam int HW  = 2 * E + 1;
   localparam int L   = E + 1;
   localparam int PW  = E + HW;
   localparam int DW  = PW + 2;
   localparam int SH  = (F > 31) ? F : 31;
   localparam int RW  = DW + SH + 1;
   localparam int QB  = rti_pkg::DIST_BITS;
   localparam int CB  = rti_pkg::CFG_BITS;
   localparam int K   = (DW + 31) / 32;
   localparam int KW  = K * 32;
   localparam int NS  = 9 + QB + 1;

   logic          adv;
   logic [NS-1:0] vld_ff;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign q_pop      = adv && q_not_empty;
   assign rsp_tvalid = vld_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NS-2:0], q_pop};
      end
   end

   // stage a: operand vectors
   logic [VW-1:0] a_vec_ff;
   always_ff @(posedge clock) begin
      if (adv) a_vec_ff <= q_data;
   end

   // stage b: cross product terms
   logic signed [E-1:0]  ca [0:11];
   logic signed [E-1:0]  cb [0:11];
   logic signed [PC-1:0] b_p_ff [0:11];
   logic [VW-1:0]        b_vec_ff;

   function automatic logic signed [E-1:0] comp(input logic [VW-1:0] v, input int n);
      return $signed(v[n*E +: E]);
   endfunction

   always_comb begin
      // h = d x e2
      ca[0] = comp(a_vec_ff, 10); cb[0] = comp(a_vec_ff, 5);
      ca[1] = comp(a_vec_ff, 11); cb[1] = comp(a_vec_ff, 4);
      ca[2] = comp(a_vec_ff, 11); cb[2] = comp(a_vec_ff, 3);
      ca[3] = comp(a_vec_ff, 9);  cb[3] = comp(a_vec_ff, 5);
      ca[4] = comp(a_vec_ff, 9);  cb[4] = comp(a_vec_ff, 4);
      ca[5] = comp(a_vec_ff, 10); cb[5] = comp(a_vec_ff, 3);
      // q = s x e1
      ca[6]  = comp(a_vec_ff, 7); cb[6]  = comp(a_vec_ff, 2);
      ca[7]  = comp(a_vec_ff, 8); cb[7]  = comp(a_vec_ff, 1);
      ca[8]  = comp(a_vec_ff, 8); cb[8]  = comp(a_vec_ff, 0);
      ca[9]  = comp(a_vec_ff, 6); cb[9]  = comp(a_vec_ff, 2);
      ca[10] = comp(a_vec_ff, 6); cb[10] = comp(a_vec_ff, 1);
      ca[11] = comp(a_vec_ff, 7); cb[11] = comp(a_vec_ff, 0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 12; k++) b_p_ff[k] <= ca[k] * cb[k];
         b_vec_ff <= a_vec_ff;
      end
   end

   // stage c: h and q
   logic signed [HW-1:0] c_hq_ff [0:5];
   logic [VW-1:0]        c_vec_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 6; i++) begin
            c_hq_ff[i] <= HW'(b_p_ff[2*i]) - HW'(b_p_ff[2*i+1]);
         end
         c_vec_ff <= b_vec_ff;
      end
   end

   // stage d: dot product terms, wide operand split in two
   logic signed [E-1:0]     da [0:11];
   logic signed [HW-1:0]    db [0:11];
   logic signed [E+L:0]     d_lo_ff [0:11];
   logic signed [2*E-1:0]   d_hi_ff [0:11];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         da[i]   = comp(c_vec_ff, i);     db[i]   = c_hq_ff[i];     // det
         da[3+i] = comp(c_vec_ff, 6+i);   db[3+i] = c_hq_ff[i];     // nu
         da[6+i] = comp(c_vec_ff, 9+i);   db[6+i] = c_hq_ff[3+i];   // nv
         da[9+i] = comp(c_vec_ff, 3+i);   db[9+i] = c_hq_ff[3+i];   // nt
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 12; k++) begin
            d_lo_ff[k] <= da[k] * $signed({1'b0, db[k][L-1:0]});
            d_hi_ff[k] <= da[k] * $signed(db[k][HW-1:L]);
         end
      end
   end

   // stage e: recombine partial products
   logic signed [PW-1:0] e_p_ff [0:11];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 12; k++) begin
            e_p_ff[k] <= (PW'(d_hi_ff[k]) <<< L) + PW'(d_lo_ff[k]);
         end
      end
   end

   // stage f: dot product sums
   logic signed [DW-1:0] f_sum_ff [0:3];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int g = 0; g < 4; g++) begin
            f_sum_ff[g] <= DW'(e_p_ff[3*g]) + DW'(e_p_ff[3*g+1]) + DW'(e_p_ff[3*g+2]);
         end
      end
   end

   // stage g: make the determinant positive
   logic signed [DW-1:0] g_det_ff, g_nu_ff, g_nv_ff, g_nt_ff;
   logic                 g_zero_ff;
   logic                 det_neg;
   assign det_neg = f_sum_ff[0][DW-1];
   always_ff @(posedge clock) begin
      if (adv) begin
         g_zero_ff <= (f_sum_ff[0] == '0);
         g_det_ff  <= det_neg ? -f_sum_ff[0] : f_sum_ff[0];
         g_nu_ff   <= det_neg ? -f_sum_ff[1] : f_sum_ff[1];
         g_nv_ff   <= det_neg ? -f_sum_ff[2] : f_sum_ff[2];
         g_nt_ff   <= det_neg ? -f_sum_ff[3] : f_sum_ff[3];
      end
   end

   // stage h: bound tests, min distance times det in 32-bit slices
   logic signed [DW:0]    nu_nv;
   logic signed [DW-1:0]  thr_ext;
   logic [KW-1:0]         det_ext;
   logic                  h_miss;
   logic                  h_miss_ff;
   logic [CB+31:0]        h_pp_ff [0:K-1];
   logic signed [RW-1:0]  h_num_ff;
   logic [DW-1:0]         h_det_ff;

   always_comb begin
      nu_nv   = (DW+1)'(g_nu_ff) + (DW+1)'(g_nv_ff);
      thr_ext = DW'($signed({1'b0, cfg.det_threshold}));
      det_ext = KW'($unsigned(g_det_ff));
      h_miss  = g_zero_ff || (g_det_ff < thr_ext) || g_nu_ff[DW-1] ||
                (g_det_ff < g_nu_ff) || g_nv_ff[DW-1] || ((DW+1)'(g_det_ff) < nu_nv);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h_miss_ff <= h_miss;
         for (int k = 0; k < K; k++) begin
            h_pp_ff[k] <= (CB+32)'(cfg.min_distance) * (CB+32)'(det_ext[32*k +: 32]);
         end
         h_num_ff <= RW'(g_nt_ff) <<< F;
         h_det_ff <= g_det_ff;
      end
   end

   // stage i: short distance and saturation tests
   logic [RW-1:0] min_scaled;
   logic [RW-1:0] det_top;
   always_comb begin
      min_scaled = '0;
      for (int k = 0; k < K; k++) begin
         min_scaled = min_scaled + (RW'(h_pp_ff[k]) << (32*k));
      end
      det_top = RW'(h_det_ff) << QB;
   end

   logic [RW-1:0] dv_rem_ff  [0:QB];
   logic [DW-1:0] dv_det_ff  [0:QB];
   logic [QB-1:0] dv_q_ff    [0:QB];
   logic          dv_miss_ff [0:QB];
   logic          dv_sat_ff  [0:QB];

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_rem_ff[0]  <= h_num_ff;
         dv_det_ff[0]  <= h_det_ff;
         dv_q_ff[0]    <= '0;
         dv_miss_ff[0] <= h_miss_ff || (h_num_ff < $signed(min_scaled));
         dv_sat_ff[0]  <= !(h_num_ff < $signed(det_top));
      end
   end

   // restoring divider, one quotient bit per stage, msb first
   for (genvar j = 0; j < QB; j++) begin : g_div
      localparam int B = QB - 1 - j;
      logic [RW-1:0] trial;
      assign trial = dv_rem_ff[j] - (RW'(dv_det_ff[j]) << B);
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_rem_ff[j+1]  <= trial[RW-1] ? dv_rem_ff[j] : trial;
            dv_q_ff[j+1]    <= dv_q_ff[j] | (QB'(!trial[RW-1]) << B);
            dv_det_ff[j+1]  <= dv_det_ff[j];
            dv_miss_ff[j+1] <= dv_miss_ff[j];
            dv_sat_ff[j+1]  <= dv_sat_ff[j];
         end
      end
   end

   // output register
   logic          o_hit_ff;
   logic [QB-1:0] o_dist_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         o_hit_ff  <= !dv_miss_ff[QB];
         o_dist_ff <= dv_miss_ff[QB] ? '0 : (dv_sat_ff[QB] ? '1 : dv_q_ff[QB]);
      end
   end

   assign rsp_tuser = o_hit_ff;
   assign rsp_tdata = {1'b0, o_dist_ff};

endmodule
`default_nettype wire

/* sv/rti_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rti_checker
// Port-level checks of the intersection unit, bound to the top level.
// ----------------------------------------------------------------------------
module rti_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic        rsp_tuser,
   input wire logic [31:0] rsp_tdata,
   input wire logic        csr_pready
);

   // nothing comes out straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // a miss reports zero distance
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 32'd0)
      else $error("miss with non-zero distance");

   // padding bit stays clear
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[31])
      else $error("distance padding set");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("register port not ready");

endmodule

bind ray_triangle_intersect_unit rti_checker u_rti_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);
`default_nettype wire
